[hw/rtl/etsh_pkg.sv]
// Shared types, constants and helper functions for the envelope transient shaper.
`timescale 1ns / 1ps
package etsh_pkg;

  localparam int unsigned SampleBits = 24;
  localparam int unsigned CoefBits   = 32;
  localparam int unsigned EnvBits    = 24;
  localparam int unsigned AvgBits    = 32;
  localparam int unsigned DelayBits  = 48;
  localparam int unsigned AmtBits    = 16;

  // 0.0005 in Q0.32 and the 1e-5 floor of the running average
  localparam logic signed [24:0] AVG_ALPHA = 25'sd2147484;
  localparam logic [31:0]        AVG_FLOOR = 32'd42949;
  localparam logic [23:0]        ENV_MAX   = 24'hFF_FFFF;

  typedef enum logic [2:0] {
    REG_ENABLE  = 3'd0,
    REG_B0      = 3'd1,
    REG_B1      = 3'd2,
    REG_B2      = 3'd3,
    REG_A1      = 3'd4,
    REG_A2      = 3'd5,
    REG_ATTACK  = 3'd6,
    REG_RELEASE = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic               enable;
    logic signed [31:0] b0;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic [23:0]        atk_coef;
    logic [23:0]        rel_coef;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_F_B0, ST_F_Y, ST_F_S1, ST_F_D0, ST_F_S2, ST_F_D1,
    ST_E_MUL, ST_E_UPD, ST_A_MUL, ST_A_UPD, ST_D_INIT, ST_D_STEP,
    ST_B_L, ST_B_R, ST_B_END, ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_B0X, MUL_B1X, MUL_A1Y, MUL_B2X, MUL_A2Y,
    MUL_ENV, MUL_AVG, MUL_BLEND
  } mul_sel_e;

  typedef enum logic [3:0] {
    POST_NONE, POST_CAPTURE, POST_Y, POST_S1, POST_D0, POST_S2, POST_D1,
    POST_ENV, POST_AVG, POST_DIV_INIT, POST_DIV_STEP, POST_BLEND, POST_OUT
  } post_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    post_e    post;
    logic     mul_ch;
    logic     post_ch;
    logic     first;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic mono;
    logic div_run;
    logic out_free;
  } status_t;

  // Clamp to a signed 24-bit sample
  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd8388607;
    lo = -64'sd8388608;
    if (v > hi) begin
      return 24'sh7F_FFFF;
    end else if (v < lo) begin
      return 24'sh80_0000;
    end
    return v[23:0];
  endfunction

  // Clamp to a signed 48-bit filter delay
  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_7FFF_FFFF_FFFF;
    lo = -64'sh0000_8000_0000_0000;
    if (v > hi) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v < lo) begin
      return 48'sh8000_0000_0000;
    end
    return v[47:0];
  endfunction

  // Peak magnitude in Q0.24, saturated
  function automatic logic [23:0] peak_of(input logic signed [23:0] x);
    logic [23:0] mag;
    logic [24:0] p;
    mag = x[23] ? 24'(-x) : x;
    p   = {mag, 1'b0};
    return p[24] ? ENV_MAX : p[23:0];
  endfunction

endpackage

[hw/rtl/envelope_transient_shaper.sv]
// Top level of the envelope transient shaper: register file, sequencer and datapath.
`timescale 1ns / 1ps
// Usage: present one frame (in_left_i, in_right_i, mono_i) with in_valid_i; it is
// taken at a rising edge where in_stall_o is low. One word comes back on
// out_valid_o with out_left_o, out_right_o and transient_amount_o, and is taken
// at an edge where out_stall_i is low. Coefficients and enable are written
// through cfg_valid_i / cfg_ready_o (always ready) with cfg_index_i and
// cfg_data_i, while the block is idle.
// Timing: an enabled frame passes through the filter states once per channel (once
// for mono), the follower and average updates, the divider unless the average sets
// the amount without it, and the blend states; a disabled frame goes straight to the
// output state. A new frame is taken in the idle state after the previous result
// moved into the output register. The cost is set by the one shared 33x25 multiplier
// (10 filter products, 2 follower, 2 blend) and the bit-per-cycle 16-step divider.
// Reset clears filter delays, both followers, output valid and registers to
// their defaults. While the receiver stalls, the finished word holds and the
// next frame is computed, then waits until the output register frees.
module envelope_transient_shaper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] in_left_i,
  input  logic signed [23:0] in_right_i,
  input  logic               mono_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] out_left_o,
  output logic signed [23:0] out_right_o,
  output logic [15:0]        transient_amount_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import etsh_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable   <= 1'b0;
      cfg_q.b0       <= 32'sd268435456;
      cfg_q.b1       <= '0;
      cfg_q.b2       <= '0;
      cfg_q.a1       <= '0;
      cfg_q.a2       <= '0;
      cfg_q.atk_coef <= 24'd16409573;
      cfg_q.rel_coef <= 24'd16773411;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_ENABLE:  cfg_q.enable   <= cfg_data_i[0];
        REG_B0:      cfg_q.b0       <= cfg_data_i;
        REG_B1:      cfg_q.b1       <= cfg_data_i;
        REG_B2:      cfg_q.b2       <= cfg_data_i;
        REG_A1:      cfg_q.a1       <= cfg_data_i;
        REG_A2:      cfg_q.a2       <= cfg_data_i;
        REG_ATTACK:  cfg_q.atk_coef <= cfg_data_i[23:0];
        REG_RELEASE: cfg_q.rel_coef <= cfg_data_i[23:0];
        default:     cfg_q.enable   <= cfg_q.enable;
      endcase
    end
  end

  etsh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  etsh_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .cmd_i              (cmd),
    .status_o           (status),
    .in_left_i          (in_left_i),
    .in_right_i         (in_right_i),
    .mono_i             (mono_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_left_o         (out_left_o),
    .out_right_o        (out_right_o),
    .transient_amount_o (transient_amount_o)
  );

endmodule

[hw/rtl/etsh_ctrl.sv]
// Sequencer of the transient shaper: steps one frame through the shared datapath.
`timescale 1ns / 1ps
module etsh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  etsh_pkg::status_t status_i,
  output etsh_pkg::cmd_t    cmd_o
);
  import etsh_pkg::*;

  state_e     state_q, state_d;
  logic       ch_q, ch_d;
  logic [3:0] cnt_q, cnt_d;

  // Advance state, channel and division count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        ch_d = 1'b0;
        if (in_valid_i) begin
          state_d = status_i.enable ? ST_F_B0 : ST_OUT;
        end
      end
      ST_F_B0: state_d = ST_F_Y;
      ST_F_Y:  state_d = ST_F_S1;
      ST_F_S1: state_d = ST_F_D0;
      ST_F_D0: state_d = ST_F_S2;
      ST_F_S2: state_d = ST_F_D1;
      ST_F_D1: begin
        if (!ch_q && !status_i.mono) begin
          ch_d    = 1'b1;
          state_d = ST_F_B0;
        end else begin
          state_d = ST_E_MUL;
        end
      end
      ST_E_MUL: state_d = ST_E_UPD;
      ST_E_UPD: state_d = ST_A_MUL;
      ST_A_MUL: state_d = ST_A_UPD;
      ST_A_UPD: state_d = ST_D_INIT;
      ST_D_INIT: begin
        cnt_d   = '0;
        state_d = status_i.div_run ? ST_D_STEP : ST_B_L;
      end
      ST_D_STEP: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          state_d = ST_B_L;
        end
      end
      ST_B_L:   state_d = ST_B_R;
      ST_B_R:   state_d = ST_B_END;
      ST_B_END: state_d = ST_OUT;
      ST_OUT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o.mul_sel = MUL_NONE;
    cmd_o.post    = POST_NONE;
    cmd_o.mul_ch  = ch_q;
    cmd_o.post_ch = ch_q;
    cmd_o.first   = (cnt_q == 4'd0);
    in_stall_o    = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE:  cmd_o.post = in_valid_i ? POST_CAPTURE : POST_NONE;
      ST_F_B0:  cmd_o.mul_sel = MUL_B0X;
      ST_F_Y: begin
        cmd_o.post    = POST_Y;
        cmd_o.mul_sel = MUL_B1X;
      end
      ST_F_S1: begin
        cmd_o.post    = POST_S1;
        cmd_o.mul_sel = MUL_A1Y;
      end
      ST_F_D0: begin
        cmd_o.post    = POST_D0;
        cmd_o.mul_sel = MUL_B2X;
      end
      ST_F_S2: begin
        cmd_o.post    = POST_S2;
        cmd_o.mul_sel = MUL_A2Y;
      end
      ST_F_D1:   cmd_o.post = POST_D1;
      ST_E_MUL:  cmd_o.mul_sel = MUL_ENV;
      ST_E_UPD:  cmd_o.post = POST_ENV;
      ST_A_MUL:  cmd_o.mul_sel = MUL_AVG;
      ST_A_UPD:  cmd_o.post = POST_AVG;
      ST_D_INIT: cmd_o.post = POST_DIV_INIT;
      ST_D_STEP: cmd_o.post = POST_DIV_STEP;
      ST_B_L: begin
        cmd_o.mul_sel = MUL_BLEND;
        cmd_o.mul_ch  = 1'b0;
      end
      ST_B_R: begin
        cmd_o.post    = POST_BLEND;
        cmd_o.post_ch = 1'b0;
        cmd_o.mul_sel = MUL_BLEND;
        cmd_o.mul_ch  = 1'b1;
      end
      ST_B_END: begin
        cmd_o.post    = POST_BLEND;
        cmd_o.post_ch = 1'b1;
      end
      ST_OUT:   cmd_o.post = status_i.out_free ? POST_OUT : POST_NONE;
      default:  cmd_o.post = POST_NONE;
    endcase
  end

endmodule

[hw/rtl/etsh_dp.sv]
// Datapath of the transient shaper: shared multiplier, filter, followers, divider.
`timescale 1ns / 1ps
module etsh_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  etsh_pkg::cfg_t     cfg_i,
  input  etsh_pkg::cmd_t     cmd_i,
  output etsh_pkg::status_t  status_o,
  input  logic signed [23:0] in_left_i,
  input  logic signed [23:0] in_right_i,
  input  logic               mono_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] out_left_o,
  output logic signed [23:0] out_right_o,
  output logic [15:0]        transient_amount_o
);
  import etsh_pkg::*;

  // Frame registers
  logic signed [23:0] xl_q, xr_q;
  logic               mono_q;
  logic [23:0]        peak_q;
  logic signed [23:0] y_q [2];
  logic signed [23:0] res_l_q, res_r_q;
  logic [15:0]        t_q;
  logic signed [49:0] acc_q;
  logic [31:0]        rem_q;
  logic               lsb_q;
  logic signed [57:0] prod_q;

  // State that persists across frames
  logic signed [47:0] s1_q [2];
  logic signed [47:0] s2_q [2];
  logic [23:0]        env_q;
  logic [31:0]        avg_q;

  // Output register
  logic               out_valid_q;
  logic signed [23:0] out_l_q, out_r_q;
  logic [15:0]        out_t_q;

  // Multiplier operands
  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [57:0] prod_d;
  logic signed [23:0] x_m, y_m;
  logic signed [24:0] env_diff, blend_diff;
  logic [23:0]        coef_sel;

  always_comb begin
    x_m        = cmd_i.mul_ch ? xr_q : xl_q;
    y_m        = y_q[cmd_i.mul_ch];
    env_diff   = {1'b0, env_q} - {1'b0, peak_q};
    coef_sel   = (peak_q > env_q) ? cfg_i.atk_coef : cfg_i.rel_coef;
    blend_diff = {y_m[23], y_m} - {x_m[23], x_m};
    mul_a      = '0;
    mul_b      = '0;
    unique case (cmd_i.mul_sel)
      MUL_B0X: begin
        mul_a = {cfg_i.b0[31], cfg_i.b0};
        mul_b = {x_m[23], x_m};
      end
      MUL_B1X: begin
        mul_a = {cfg_i.b1[31], cfg_i.b1};
        mul_b = {x_m[23], x_m};
      end
      MUL_A1Y: begin
        mul_a = {cfg_i.a1[31], cfg_i.a1};
        mul_b = {y_m[23], y_m};
      end
      MUL_B2X: begin
        mul_a = {cfg_i.b2[31], cfg_i.b2};
        mul_b = {x_m[23], x_m};
      end
      MUL_A2Y: begin
        mul_a = {cfg_i.a2[31], cfg_i.a2};
        mul_b = {y_m[23], y_m};
      end
      MUL_ENV: begin
        mul_a = {{8{env_diff[24]}}, env_diff};
        mul_b = {1'b0, coef_sel};
      end
      MUL_AVG: begin
        mul_a = {1'b0, env_q, 8'b0} - {1'b0, avg_q};
        mul_b = AVG_ALPHA;
      end
      MUL_BLEND: begin
        mul_a = {{8{blend_diff[24]}}, blend_diff};
        mul_b = {9'b0, t_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Post-processing of the registered product
  logic signed [42:0] prod_sh;
  logic signed [47:0] s1_p, s2_p;
  logic signed [23:0] x_p;
  logic signed [49:0] acc_y, y_shift;
  logic signed [23:0] y_new;
  logic signed [50:0] dly_v;
  logic signed [47:0] dly_sat;
  logic [31:0]        env32;
  logic [32:0]        avg_diff;
  logic               avg_ok, div_sat;
  logic [32:0]        rem2, rem_sub;
  logic               rem_ge;
  logic signed [42:0] blend_sum;
  logic signed [23:0] blend_v;
  logic               out_free;

  always_comb begin
    prod_sh   = prod_q[57:15];
    s1_p      = s1_q[cmd_i.post_ch];
    s2_p      = s2_q[cmd_i.post_ch];
    x_p       = cmd_i.post_ch ? xr_q : xl_q;
    acc_y     = {{7{prod_sh[42]}}, prod_sh} + {{2{s1_p[47]}}, s1_p};
    y_shift   = acc_y >>> 13;
    y_new     = sat24({{14{y_shift[49]}}, y_shift});
    dly_v     = {acc_q[49], acc_q} - {{8{prod_sh[42]}}, prod_sh};
    dly_sat   = sat48({{13{dly_v[50]}}, dly_v});
    env32     = {env_q, 8'b0};
    avg_diff  = {1'b0, env32} - {1'b0, avg_q};
    avg_ok    = (avg_q > AVG_FLOOR) && (env32 > avg_q);
    div_sat   = {1'b0, avg_diff[31:0]} >= {avg_q, 1'b0};
    rem2      = {rem_q, cmd_i.first ? lsb_q : 1'b0};
    rem_sub   = rem2 - {1'b0, avg_q};
    rem_ge    = rem2 >= {1'b0, avg_q};
    blend_sum = {{19{x_p[23]}}, x_p} + {prod_q[57], prod_q[57:16]};
    blend_v   = sat24({{21{blend_sum[42]}}, blend_sum});
    out_free  = !out_valid_q || !out_stall_i;
  end

  assign status_o.enable   = cfg_i.enable;
  assign status_o.mono     = mono_q;
  assign status_o.div_run  = avg_ok && !div_sat;
  assign status_o.out_free = out_free;

  // Register the multiplier product for post-processing
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Frame working registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.post)
      POST_CAPTURE: begin
        xl_q    <= in_left_i;
        xr_q    <= mono_i ? '0 : in_right_i;
        mono_q  <= mono_i;
        peak_q  <= (mono_i || peak_of(in_left_i) >= peak_of(in_right_i)) ?
                   peak_of(in_left_i) : peak_of(in_right_i);
        res_l_q <= in_left_i;
        res_r_q <= mono_i ? '0 : in_right_i;
        t_q     <= '0;
      end
      POST_Y:  y_q[cmd_i.post_ch] <= y_new;
      POST_S1: acc_q <= {{7{prod_sh[42]}}, prod_sh} + {{2{s2_p[47]}}, s2_p};
      POST_S2: acc_q <= {{7{prod_sh[42]}}, prod_sh};
      POST_DIV_INIT: begin
        t_q   <= (avg_ok && div_sat) ? 16'hFFFF : 16'h0000;
        rem_q <= {1'b0, avg_diff[31:1]};
        lsb_q <= avg_diff[0];
      end
      POST_DIV_STEP: begin
        rem_q <= rem_ge ? rem_sub[31:0] : rem2[31:0];
        t_q   <= {t_q[14:0], rem_ge};
      end
      POST_BLEND: begin
        if (cmd_i.post_ch) begin
          res_r_q <= mono_q ? '0 : blend_v;
        end else begin
          res_l_q <= blend_v;
        end
      end
      default: begin
      end
    endcase
  end

  // Filter delays and followers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q[0] <= '0;
      s1_q[1] <= '0;
      s2_q[0] <= '0;
      s2_q[1] <= '0;
      env_q   <= '0;
      avg_q   <= '0;
    end else begin
      unique case (cmd_i.post)
        POST_D0:  s1_q[cmd_i.post_ch] <= dly_sat;
        POST_D1:  s2_q[cmd_i.post_ch] <= dly_sat;
        POST_ENV: env_q <= peak_q + prod_q[47:24];
        POST_AVG: avg_q <= avg_q + {{6{prod_q[57]}}, prod_q[57:32]};
        default: begin
        end
      endcase
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.post == POST_OUT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.post == POST_OUT) begin
      out_l_q <= res_l_q;
      out_r_q <= res_r_q;
      out_t_q <= t_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_left_o         = out_l_q;
  assign out_right_o        = out_r_q;
  assign transient_amount_o = out_t_q;

  // Division remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.post == POST_DIV_STEP) |-> (rem_q < avg_q))
    else $error("divider remainder not below divisor");

  // Follower lands between its old value and the peak
  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.post == POST_ENV) |=>
      ((env_q <= $past(peak_q)) || (env_q <= $past(env_q))) &&
      ((env_q >= $past(peak_q)) || (env_q >= $past(env_q))))
    else $error("envelope left its bounds");

  // Output word appears only on a load command
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.post == POST_OUT))
    else $error("output valid without load");

endmodule
